// File: hdl/bpsd_pkg.sv
`default_nettype none
package bpsd_pkg;

    localparam int NUM_AXES   = 8;
    localparam int DIST_BITS  = 8;
    // fixed layout of the stream payload
    localparam int FIELD_W    = 8;
    localparam int MAX_AXES   = 8;
    localparam int IN_DATA_W  = (MAX_AXES + 1) * FIELD_W;
    localparam int OUT_DATA_W = 2 * FIELD_W;
    localparam int IDX_W      = DIST_BITS;
    localparam int BIT_W      = (DIST_BITS > 1) ? $clog2(DIST_BITS) : 1;
    localparam int RUL_W      = $clog2(DIST_BITS + 1);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic [DIST_BITS-1:0] count_t;
    typedef logic [NUM_AXES-1:0]  axes_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [BIT_W-1:0]     bit_sel_t;
    typedef logic [RUL_W-1:0]     ruler_t;

    // plane pick for the current index and for the one below it
    typedef struct packed {
        logic     hit_now;
        bit_sel_t sel_now;
        logic     hit_prev;
        bit_sel_t sel_prev;
    } lane_ctl_t;

    typedef struct packed {
        axes_t step_mask;
        logic  use_prev;
    } merge_res_t;

    // number of trailing ones of the index
    function automatic ruler_t ruler(input idx_t v);
        ruler_t r;
        logic   run;
        r   = '0;
        run = 1'b1;
        for (int i = 0; i < IDX_W; i++)
        begin
            run = run & v[i];
            if (run)
            begin
                r = r + ruler_t'(1);
            end
        end
        return r;
    endfunction

    // 2^(top+1) - 2
    function automatic idx_t start_index(input bit_sel_t top);
        idx_t ones;
        ones    = {IDX_W{1'b1}} >> (IDX_W - 1 - int'(top));
        ones[0] = 1'b0;
        return ones;
    endfunction

endpackage
`default_nettype wire

// File: hdl/bpsd_lane.sv
`default_nettype none
module bpsd_lane (
    input  wire bpsd_pkg::count_t    cnt,
    input  wire bpsd_pkg::lane_ctl_t ctl,
    output logic                     bit_now,
    output logic                     bit_prev
);

    // plane r of the run is count bit (top - r)
    assign bit_now  = ctl.hit_now  & cnt[ctl.sel_now];
    assign bit_prev = ctl.hit_prev & cnt[ctl.sel_prev];

endmodule
`default_nettype wire

// File: hdl/bpsd_merge.sv
`default_nettype none
module bpsd_merge (
    input  wire bpsd_pkg::axes_t       plane_now,
    input  wire bpsd_pkg::axes_t       plane_prev,
    input  wire                        idx_nonzero,
    output bpsd_pkg::merge_res_t       res
);

    logic empty_now;

    assign empty_now = (plane_now == '0);

    always_comb
    begin
        // an empty plane is skipped in favor of the next index down
        res.use_prev  = empty_now & idx_nonzero;
        res.step_mask = res.use_prev ? plane_prev : plane_now;
    end

endmodule
`default_nettype wire

// File: hdl/bit_plane_step_distributor_core.sv
// a result is in the output register in the cycle after its request is accepted
// throughput: one request per cycle; a new request is taken while a result waits,
// as long as the output register is free or being drained in the same cycle
// the step pattern comes from one pass through the per-axis lanes and the merge
// reset: asynchronous, clears the active run, the pending buffer and the output valid
`default_nettype none
module bit_plane_step_distributor_core (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // dist_a0, dist_a1, ..., dist_a7, neg_mask
    input  wire [bpsd_pkg::IN_DATA_W-1:0]       s_tdata,
    // req_type
    input  wire [0:0]                           s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // step_mask, dir_mask
    output logic [bpsd_pkg::OUT_DATA_W-1:0]     m_tdata,
    // step_valid, load_taken
    output logic [1:0]                          m_tuser,
    // run_end
    output logic                                m_tlast
);

    bpsd_pkg::count_t   cur_cnt_reg  [bpsd_pkg::NUM_AXES];
    bpsd_pkg::count_t   cur_cnt_next [bpsd_pkg::NUM_AXES];
    bpsd_pkg::count_t   nxt_cnt_reg  [bpsd_pkg::NUM_AXES];
    bpsd_pkg::count_t   nxt_cnt_next [bpsd_pkg::NUM_AXES];
    bpsd_pkg::count_t   load_cnt     [bpsd_pkg::NUM_AXES];
    bpsd_pkg::bit_sel_t cur_top_reg, cur_top_next, nxt_top_reg, nxt_top_next, load_top;
    bpsd_pkg::idx_t     cur_idx_reg, cur_idx_next, nxt_idx_reg, nxt_idx_next;
    bpsd_pkg::axes_t    cur_dir_reg, cur_dir_next, nxt_dir_reg, nxt_dir_next, load_dir;
    logic               run_active_reg, run_active_next;
    logic               next_valid_reg, next_valid_next;

    logic               m_tvalid_reg, m_tvalid_next;
    bpsd_pkg::axes_t    out_step_reg, out_step_next;
    bpsd_pkg::axes_t    out_dir_reg, out_dir_next;
    logic               out_sv_reg, out_sv_next;
    logic               out_end_reg, out_end_next;
    logic               out_taken_reg, out_taken_next;

    logic               accept, is_load, is_tick;
    bpsd_pkg::count_t   all_bits;
    bpsd_pkg::idx_t     idx_prev, idx_eff;
    bpsd_pkg::ruler_t   rul_now, rul_prev, top_ext;
    bpsd_pkg::lane_ctl_t lane_ctl;
    bpsd_pkg::axes_t    plane_now, plane_prev;
    bpsd_pkg::merge_res_t merged;
    logic               run_end;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_load  = accept && (s_tuser[0] == bpsd_pkg::REQ_LOAD);
    assign is_tick  = accept && (s_tuser[0] == bpsd_pkg::REQ_TICK);

    // unpack the load and find the depth of the sub-motion
    always_comb
    begin
        all_bits = '0;
        for (int a = 0; a < bpsd_pkg::NUM_AXES; a++)
        begin
            load_cnt[a] = s_tdata[a*bpsd_pkg::FIELD_W +: bpsd_pkg::DIST_BITS];
            all_bits    = all_bits | load_cnt[a];
        end
        load_top = '0;
        for (int p = 0; p < bpsd_pkg::DIST_BITS; p++)
        begin
            if (all_bits[p])
            begin
                load_top = bpsd_pkg::bit_sel_t'(p);
            end
        end
        load_dir = s_tdata[bpsd_pkg::MAX_AXES*bpsd_pkg::FIELD_W +: bpsd_pkg::NUM_AXES];
    end

    // plane selection shared by all lanes
    assign idx_prev = cur_idx_reg - bpsd_pkg::idx_t'(1);
    assign rul_now  = bpsd_pkg::ruler(cur_idx_reg);
    assign rul_prev = bpsd_pkg::ruler(idx_prev);
    assign top_ext  = bpsd_pkg::ruler_t'(cur_top_reg);

    always_comb
    begin
        lane_ctl.hit_now  = (rul_now <= top_ext);
        lane_ctl.sel_now  = bpsd_pkg::bit_sel_t'(top_ext - rul_now);
        lane_ctl.hit_prev = (rul_prev <= top_ext);
        lane_ctl.sel_prev = bpsd_pkg::bit_sel_t'(top_ext - rul_prev);
    end

    for (genvar a = 0; a < bpsd_pkg::NUM_AXES; a++)
    begin : g_lane
        bpsd_lane u_lane (
            .cnt      (cur_cnt_reg[a]),
            .ctl      (lane_ctl),
            .bit_now  (plane_now[a]),
            .bit_prev (plane_prev[a])
        );
    end

    bpsd_merge u_merge (
        .plane_now   (plane_now),
        .plane_prev  (plane_prev),
        .idx_nonzero (cur_idx_reg != '0),
        .res         (merged)
    );

    assign idx_eff = merged.use_prev ? idx_prev : cur_idx_reg;
    assign run_end = (idx_eff == '0);

    // run and pending buffer update
    always_comb
    begin
        cur_cnt_next    = cur_cnt_reg;
        nxt_cnt_next    = nxt_cnt_reg;
        cur_top_next    = cur_top_reg;
        nxt_top_next    = nxt_top_reg;
        cur_idx_next    = cur_idx_reg;
        nxt_idx_next    = nxt_idx_reg;
        cur_dir_next    = cur_dir_reg;
        nxt_dir_next    = nxt_dir_reg;
        run_active_next = run_active_reg;
        next_valid_next = next_valid_reg;
        out_taken_next  = 1'b0;
        if (is_load)
        begin
            if (!run_active_reg)
            begin
                cur_cnt_next    = load_cnt;
                cur_top_next    = load_top;
                cur_idx_next    = bpsd_pkg::start_index(load_top);
                cur_dir_next    = load_dir;
                run_active_next = 1'b1;
                out_taken_next  = 1'b1;
            end
            else if (!next_valid_reg)
            begin
                nxt_cnt_next    = load_cnt;
                nxt_top_next    = load_top;
                nxt_idx_next    = bpsd_pkg::start_index(load_top);
                nxt_dir_next    = load_dir;
                next_valid_next = 1'b1;
                out_taken_next  = 1'b1;
            end
        end
        else if (is_tick && run_active_reg)
        begin
            if (!run_end)
            begin
                cur_idx_next = idx_eff - bpsd_pkg::idx_t'(1);
            end
            else if (next_valid_reg)
            begin
                cur_cnt_next    = nxt_cnt_reg;
                cur_top_next    = nxt_top_reg;
                cur_idx_next    = nxt_idx_reg;
                cur_dir_next    = nxt_dir_reg;
                next_valid_next = 1'b0;
            end
            else
            begin
                run_active_next = 1'b0;
            end
        end
    end

    // result of this request
    always_comb
    begin
        out_step_next = '0;
        out_dir_next  = '0;
        out_sv_next   = 1'b0;
        out_end_next  = 1'b0;
        if (is_tick && run_active_reg)
        begin
            out_step_next = merged.step_mask;
            out_dir_next  = cur_dir_reg;
            out_sv_next   = 1'b1;
            out_end_next  = run_end;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            next_valid_reg <= 1'b0;
            cur_idx_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            run_active_reg <= run_active_next;
            next_valid_reg <= next_valid_next;
            cur_idx_reg    <= cur_idx_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_cnt_reg <= cur_cnt_next;
        nxt_cnt_reg <= nxt_cnt_next;
        cur_top_reg <= cur_top_next;
        nxt_top_reg <= nxt_top_next;
        nxt_idx_reg <= nxt_idx_next;
        cur_dir_reg <= cur_dir_next;
        nxt_dir_reg <= nxt_dir_next;
        if (accept)
        begin
            out_step_reg  <= out_step_next;
            out_dir_reg   <= out_dir_next;
            out_sv_reg    <= out_sv_next;
            out_end_reg   <= out_end_next;
            out_taken_reg <= out_taken_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {bpsd_pkg::FIELD_W'(out_dir_reg), bpsd_pkg::FIELD_W'(out_step_reg)};
    assign m_tuser  = {out_taken_reg, out_sv_reg};
    assign m_tlast  = out_end_reg;

endmodule
`default_nettype wire

// File: hdl/bpsd_checker.sv
`default_nettype none
module bpsd_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire [bpsd_pkg::IN_DATA_W-1:0]    s_tdata,
    input wire [0:0]                        s_tuser,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [bpsd_pkg::OUT_DATA_W-1:0]   m_tdata,
    input wire [1:0]                        m_tuser,
    input wire                              m_tlast
);

    // every accepted request leaves a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted request");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // run end only on an emitted step
    a_end_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("run end without step");

    // a step result never reports a taken load
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("step and load flags both set");

    // results without a step carry no pattern
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tlast)
        else $error("non-step result carries data");

endmodule

bind bit_plane_step_distributor_core bpsd_checker u_bpsd_checker (.*);
`default_nettype wire

// File: tb/tb_bit_plane_step_distributor_core.sv
`default_nettype none
module tb_bit_plane_step_distributor_core;

    typedef logic [7:0][7:0] plane_set_t;

    typedef struct packed {
        logic [7:0] step_mask;
        logic [7:0] dir_mask;
        logic       step_valid;
        logic       run_end;
        logic       load_taken;
    } step_res_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bpsd_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [0:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [bpsd_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [1:0]                      m_tuser;
    logic                            m_tlast;

    bit_plane_step_distributor_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // predicted distributor state
    plane_set_t active_planes;
    plane_set_t pending_planes;
    logic [7:0] tick_index;
    logic [7:0] pending_start;
    logic [7:0] active_dir;
    logic [7:0] pending_dir;
    bit         run_active;
    bit         pending_full;

    step_res_t  pattern_q[$];
    int         mismatch_cnt;
    int         request_cnt;
    bit         quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("bit_plane_step_distributor_core: mismatch");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            return $urandom_range(1, 2);
        end
        else if (r < 9)
        begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(10, 40);
    endfunction

    // plane picked by the number of trailing ones of the index
    function automatic logic [7:0] plane_for_index(input logic [7:0] idx);
        int r;
        r = 0;
        while (r < 8 && idx[r])
        begin
            r++;
        end
        return (r < 8) ? active_planes[r] : 8'h00;
    endfunction

    // transpose counts into planes, top plane first; returns the start index
    function automatic logic [7:0] split_counts(input logic [bpsd_pkg::IN_DATA_W-1:0] d,
                                                output plane_set_t planes);
        plane_set_t raw;
        logic [7:0] seen_bits;
        logic [7:0] cnt;
        int         depth;
        raw       = '0;
        seen_bits = '0;
        planes    = '0;
        for (int a = 0; a < bpsd_pkg::NUM_AXES; a++)
        begin
            cnt       = d[a*bpsd_pkg::FIELD_W +: 8] & 8'((1 << bpsd_pkg::DIST_BITS) - 1);
            seen_bits = seen_bits | cnt;
            for (int p = 0; p < bpsd_pkg::DIST_BITS; p++)
            begin
                if (cnt[p])
                begin
                    raw[p][a] = 1'b1;
                end
            end
        end
        depth = 1;
        for (int p = 0; p < 8; p++)
        begin
            if (seen_bits[p])
            begin
                depth = p + 1;
            end
        end
        for (int p = 0; p < depth; p++)
        begin
            planes[p] = raw[depth - 1 - p];
        end
        return 8'((1 << depth) - 2);
    endfunction

    task automatic apply_request(input logic req, input logic [bpsd_pkg::IN_DATA_W-1:0] d,
                                 output step_res_t res);
        logic [7:0] pat;
        logic [7:0] dir;
        res = '0;
        dir = d[bpsd_pkg::MAX_AXES*bpsd_pkg::FIELD_W +: 8]
              & 8'((1 << bpsd_pkg::NUM_AXES) - 1);
        if (req == bpsd_pkg::REQ_LOAD)
        begin
            if (!run_active)
            begin
                tick_index     = split_counts(d, active_planes);
                active_dir     = dir;
                run_active     = 1'b1;
                res.load_taken = 1'b1;
            end
            else if (!pending_full)
            begin
                pending_start  = split_counts(d, pending_planes);
                pending_dir    = dir;
                pending_full   = 1'b1;
                res.load_taken = 1'b1;
            end
        end
        else if (run_active)
        begin
            pat = plane_for_index(tick_index);
            // empty plane: fall through to the index below
            if (pat == 8'h00 && tick_index != 8'h00)
            begin
                tick_index = tick_index - 8'd1;
                pat        = plane_for_index(tick_index);
            end
            res.step_mask  = pat & 8'((1 << bpsd_pkg::NUM_AXES) - 1);
            res.dir_mask   = active_dir;
            res.step_valid = 1'b1;
            if (tick_index == 8'h00)
            begin
                res.run_end = 1'b1;
                if (pending_full)
                begin
                    active_planes = pending_planes;
                    tick_index    = pending_start;
                    active_dir    = pending_dir;
                    pending_full  = 1'b0;
                end
                else
                begin
                    run_active = 1'b0;
                end
            end
            else
            begin
                tick_index = tick_index - 8'd1;
            end
        end
    endtask

    // called and returns at a falling edge
    task automatic push_request(input logic req, input logic [bpsd_pkg::IN_DATA_W-1:0] d);
        step_res_t res;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap_len()) @(negedge clk);
        end
        s_tvalid   = 1'b1;
        s_tuser[0] = req;
        s_tdata    = d;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        apply_request(req, d, res);
        pattern_q.push_back(res);
        request_cnt++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [bpsd_pkg::IN_DATA_W-1:0] random_load();
        logic [bpsd_pkg::IN_DATA_W-1:0] d;
        logic [7:0]                     m;
        int                             r;
        int                             depth;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            depth = $urandom_range(1, 4);
        end
        else if (r < 95)
        begin
            depth = $urandom_range(5, 6);
        end
        else
        begin
            depth = $urandom_range(7, 8);
        end
        m = 8'((1 << depth) - 1);
        d = '0;
        for (int a = 0; a < bpsd_pkg::MAX_AXES; a++)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                d[a*bpsd_pkg::FIELD_W +: 8] = 8'($urandom) & m;
            end
        end
        d[bpsd_pkg::MAX_AXES*bpsd_pkg::FIELD_W +: 8] = 8'($urandom);
        return d;
    endfunction

    task automatic tick_until_idle();
        while (run_active)
        begin
            push_request(bpsd_pkg::REQ_TICK, 72'($urandom));
        end
    endtask

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("result error on %s: expected %0h, got %0h", what, exp_v, got_v);
        mismatch_cnt++;
    endtask

    always @(posedge clk)
    begin
        step_res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pattern_q.size() == 0)
            begin
                report_mismatch("unrequested result", 0, m_tdata);
            end
            else
            begin
                e = pattern_q.pop_front();
                if (m_tdata[7:0] !== e.step_mask)
                begin
                    report_mismatch("step_mask", e.step_mask, m_tdata[7:0]);
                end
                if (m_tdata[15:8] !== e.dir_mask)
                begin
                    report_mismatch("dir_mask", e.dir_mask, m_tdata[15:8]);
                end
                if (m_tuser[0] !== e.step_valid)
                begin
                    report_mismatch("step_valid", e.step_valid, m_tuser[0]);
                end
                if (m_tuser[1] !== e.load_taken)
                begin
                    report_mismatch("load_taken", e.load_taken, m_tuser[1]);
                end
                if (m_tlast !== e.run_end)
                begin
                    report_mismatch("run_end", e.run_end, m_tlast);
                end
            end
        end
    end

    // receiver side stalls
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready = 1'b0;
                repeat (gap_len()) @(negedge clk);
            end
            m_tready = 1'b1;
        end
    end

    task automatic test_idle_ticks();
        push_request(bpsd_pkg::REQ_TICK, '1);
        push_request(bpsd_pkg::REQ_TICK, '0);
    endtask

    task automatic test_empty_load();
        push_request(bpsd_pkg::REQ_LOAD, {8'hff, 64'h0});
        push_request(bpsd_pkg::REQ_TICK, '0);
        push_request(bpsd_pkg::REQ_TICK, '0);
    endtask

    // axis 0 = 5 and axis 3 = 1 leave the middle plane empty
    task automatic test_zero_plane();
        push_request(bpsd_pkg::REQ_LOAD,
                     {8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h05});
        tick_until_idle();
    endtask

    task automatic test_pending_and_drop();
        // let everything drain before the back-to-back loads
        while (pattern_q.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        push_request(bpsd_pkg::REQ_LOAD, {8'ha5, 56'h0, 8'h01});
        push_request(bpsd_pkg::REQ_LOAD, {8'h5a, {8{8'hff}}});
        push_request(bpsd_pkg::REQ_LOAD, random_load());
        // ends the short run; the full-count run takes over and is left running
        push_request(bpsd_pkg::REQ_TICK, '0);
    endtask

    task automatic test_random_runs();
        while (request_cnt < 1040)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 85)
            begin
                push_request(bpsd_pkg::REQ_LOAD, random_load());
                while (run_active)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        push_request(bpsd_pkg::REQ_LOAD, random_load());
                    end
                    else
                    begin
                        push_request(bpsd_pkg::REQ_TICK, 72'($urandom));
                    end
                end
            end
            else
            begin
                push_request(1'($urandom), random_load());
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        int waited;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        quiet          = 1'b0;
        mismatch_cnt   = 0;
        request_cnt    = 0;
        active_planes  = '0;
        pending_planes = '0;
        tick_index     = '0;
        pending_start  = '0;
        active_dir     = '0;
        pending_dir    = '0;
        run_active     = 1'b0;
        pending_full   = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_ticks();
        test_empty_load();
        test_zero_plane();
        test_pending_and_drop();
        test_random_runs();

        s_tvalid = 1'b0;
        waited   = 0;
        while (pattern_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (pattern_q.size() != 0)
        begin
            report_mismatch("results never delivered", pattern_q.size(), 0);
        end
        if (mismatch_cnt == 0)
        begin
            $display("bit_plane_step_distributor_core: match");
        end
        else
        begin
            $display("bit_plane_step_distributor_core: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
